// ----- src/assert_macros.svh -----
// Assertion macros for the checker of the allocator.
// No dependencies; included by ffla_checker.sv, which holds the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication under clock and active-low reset.
`define FFLA_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");
// Next-cycle implication under clock and active-low reset.
`define FFLA_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");
`endif

// ----- src/ffla_pkg.sv -----
// Package of the first-fit free list allocator: codes, cell type, constants.
// No dependencies; used by the top level, the checker and the testbench.
package ffla_pkg;
	localparam int POOL_PAGES_DEF = 16;
	localparam int PAGE_UNITS_DEF = 256;
	localparam int UNIT_SHIFT = 4;
	localparam int UNIT_BYTES = 1 << UNIT_SHIFT;
	localparam int CELL_W = 17;
	localparam int OUT_W = 13;
	localparam int LIMIT_W = 5;
	localparam int LIMIT_RESET = 16;

	typedef struct packed {
		logic [CELL_W-1:0] units;
		logic [CELL_W-1:0] next;
	} cell_t;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_Q_RD, S_Q_DO,
		S_R_WALK_RD, S_R_WALK, S_R_B_RD, S_R_B, S_R_N, S_R_W1,
		S_R_AT_RD, S_R_AT, S_R_BB,
		S_G_START, S_G_FIRST, S_G_CUR, S_G_ADV_RD, S_G_ADV,
		S_G_S_RD, S_G_S, S_G_WIN,
		S_PUT_RD, S_PUT_WR, S_FIN
	} state_t;
endpackage

// ----- src/first_fit_free_list_allocator_unit.sv -----
// Top level of the first-fit free list allocator: sequencer and heap memory.
// Depends on ffla_pkg and ffla_ram.
//
// The heap cells live in one RAM of 1+POOL_PAGES*PAGE_UNITS entries. After reset a
// clearing pass writes every entry once, one per cycle, with busy high. A request is
// taken when start is high and busy low; its result appears for one cycle with done
// and cannot be held off. A free walks the free list from the rover and merges the
// block with its neighbours; an allocate walks the list for the first block that
// fits, splits it when it is larger, and takes a new pool page when the walk wraps.
module first_fit_free_list_allocator_unit #(
	parameter int POOL_PAGES = ffla_pkg::POOL_PAGES_DEF,
	parameter int PAGE_UNITS = ffla_pkg::PAGE_UNITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic [11:0]                       size_bytes,
	input  logic [ffla_pkg::OUT_W-1:0]        block_addr,
	input  logic                              page_limit_we,
	input  logic [ffla_pkg::LIMIT_W-1:0]      page_limit,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [ffla_pkg::OUT_W-1:0]        result_addr,
	output logic [ffla_pkg::OUT_W-1:0]        block_bytes
);
	localparam int CW = ffla_pkg::CELL_W;
	localparam int OW = ffla_pkg::OUT_W;
	localparam int DEPTH = 1 + POOL_PAGES * PAGE_UNITS;
	localparam int AW = $clog2(DEPTH);
	localparam int WALK_LIMIT = (POOL_PAGES + 2) * DEPTH;
	localparam int SW = $clog2(WALK_LIMIT + 1);
	localparam int PW = $clog2(POOL_PAGES + 1);
	localparam int TOO_LARGE_AT = PAGE_UNITS * ffla_pkg::UNIT_BYTES - ffla_pkg::UNIT_BYTES;

	ffla_pkg::state_t state_q, nxt, ret_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] rover_q;
	logic [PW-1:0] pages_q;
	logic [ffla_pkg::LIMIT_W-1:0] limit_q;
	logic done_q, rd_oob_q, rel_grant_q, put_sel_q;
	logic [CW-1:0] put_addr_q, put_val_q;
	logic [CW-1:0] need_q, b_q, at_q, na_q, ub_q, un_q, nn_q, ua_q;
	logic [CW-1:0] prev_q, cur_q;
	logic [SW-1:0] rsteps_q, gsteps_q;
	ffla_pkg::status_t res_status_q;
	logic [OW-1:0] res_addr_q, res_bytes_q;

	logic [CW-1:0] mem_raddr, mem_waddr;
	logic mem_we;
	ffla_pkg::cell_t mem_wdata, ram_rdata, rd;
	logic r_found, r_over, g_hit, g_exact, g_wrap, g_nopage, g_over;
	logic merge1, merge2, too_large, addr_ok;
	logic [CW-1:0] need_in, h_in, rest, base;
	logic [CW+ffla_pkg::UNIT_SHIFT-1:0] qbytes;

	ffla_ram #(.W($bits(ffla_pkg::cell_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr[AW-1:0]),
		.wdata (mem_wdata),
		.raddr (mem_raddr[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign rd = rd_oob_q ? '0 : ram_rdata;
	assign r_found = (b_q > at_q && b_q < rd.next) ||
		(at_q >= rd.next && (b_q > at_q || b_q < rd.next));
	assign r_over = rsteps_q >= SW'(WALK_LIMIT);
	assign g_over = gsteps_q >= SW'(WALK_LIMIT);
	assign g_hit = cur_q != '0 && rd.units >= need_q;
	assign g_exact = rd.units == need_q;
	assign g_wrap = cur_q == rover_q;
	assign g_nopage = CW'(pages_q) >= CW'(limit_q) || CW'(pages_q) >= CW'(POOL_PAGES);
	assign merge1 = na_q != '0 && CW'(b_q + ub_q) == na_q;
	assign merge2 = at_q != '0 && CW'(at_q + ua_q) == b_q;
	assign rest = CW'(cur_q + need_q);
	assign base = CW'(1) + CW'(pages_q) * CW'(PAGE_UNITS);
	assign too_large = 32'(size_bytes) >= 32'(TOO_LARGE_AT);
	assign need_in = (CW'(size_bytes) + CW'(2 * ffla_pkg::UNIT_BYTES - 1)) >>
		ffla_pkg::UNIT_SHIFT;
	assign h_in = CW'(block_addr) - CW'(1);
	assign addr_ok = block_addr >= OW'(2) && h_in < CW'(DEPTH);
	assign qbytes = {rd.units, {ffla_pkg::UNIT_SHIFT{1'b0}}};

	assign busy = state_q != ffla_pkg::S_IDLE;
	assign done = done_q;
	assign status = res_status_q;
	assign result_addr = res_addr_q;
	assign block_bytes = res_bytes_q;

	always_comb begin
		nxt = state_q;
		unique case (state_q)
			ffla_pkg::S_CLEAR: if (clr_q == AW'(DEPTH - 1)) nxt = ffla_pkg::S_IDLE;
			ffla_pkg::S_IDLE: begin
				if (start) begin
					unique case (ffla_pkg::req_t'(req_type))
						ffla_pkg::REQ_ALLOC:
							nxt = too_large ? ffla_pkg::S_FIN : ffla_pkg::S_G_START;
						ffla_pkg::REQ_FREE:
							nxt = addr_ok ? ffla_pkg::S_R_WALK_RD : ffla_pkg::S_FIN;
						ffla_pkg::REQ_QUERY:
							nxt = addr_ok ? ffla_pkg::S_Q_RD : ffla_pkg::S_FIN;
						default: nxt = ffla_pkg::S_FIN;
					endcase
				end
			end
			ffla_pkg::S_Q_RD: nxt = ffla_pkg::S_Q_DO;
			ffla_pkg::S_Q_DO: nxt = ffla_pkg::S_FIN;
			ffla_pkg::S_R_WALK_RD: nxt = ffla_pkg::S_R_WALK;
			ffla_pkg::S_R_WALK: begin
				if (r_found) nxt = ffla_pkg::S_R_B_RD;
				else if (r_over) nxt = ffla_pkg::S_FIN;
			end
			ffla_pkg::S_R_B_RD: nxt = ffla_pkg::S_R_B;
			ffla_pkg::S_R_B: nxt = (na_q != '0) ? ffla_pkg::S_R_N : ffla_pkg::S_R_W1;
			ffla_pkg::S_R_N: nxt = ffla_pkg::S_R_W1;
			ffla_pkg::S_R_W1: nxt = ffla_pkg::S_R_AT_RD;
			ffla_pkg::S_R_AT_RD: nxt = ffla_pkg::S_R_AT;
			ffla_pkg::S_R_AT: nxt = ffla_pkg::S_R_BB;
			ffla_pkg::S_R_BB: nxt = rel_grant_q ? ffla_pkg::S_G_ADV_RD : ffla_pkg::S_FIN;
			ffla_pkg::S_G_START: nxt = ffla_pkg::S_G_FIRST;
			ffla_pkg::S_G_FIRST: nxt = ffla_pkg::S_G_CUR;
			ffla_pkg::S_G_CUR: begin
				if (g_hit) nxt = ffla_pkg::S_PUT_RD;
				else if (g_wrap) nxt = g_nopage ? ffla_pkg::S_FIN : ffla_pkg::S_PUT_RD;
				else if (g_over) nxt = ffla_pkg::S_FIN;
			end
			ffla_pkg::S_G_ADV_RD: nxt = ffla_pkg::S_G_ADV;
			ffla_pkg::S_G_ADV: nxt = g_over ? ffla_pkg::S_FIN : ffla_pkg::S_G_CUR;
			ffla_pkg::S_G_S_RD: nxt = ffla_pkg::S_G_S;
			ffla_pkg::S_G_S: nxt = ffla_pkg::S_PUT_RD;
			ffla_pkg::S_G_WIN: nxt = ffla_pkg::S_FIN;
			ffla_pkg::S_PUT_RD: nxt = ffla_pkg::S_PUT_WR;
			ffla_pkg::S_PUT_WR: nxt = ret_q;
			ffla_pkg::S_FIN: nxt = ffla_pkg::S_IDLE;
			default: nxt = ffla_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_raddr = '0;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (state_q)
			ffla_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = CW'(clr_q);
				mem_wdata.units = (clr_q == '0) ? CW'(1) : '0;
			end
			ffla_pkg::S_Q_RD: mem_raddr = b_q;
			ffla_pkg::S_R_WALK_RD: mem_raddr = at_q;
			ffla_pkg::S_R_WALK: mem_raddr = rd.next;
			ffla_pkg::S_R_B_RD: mem_raddr = b_q;
			ffla_pkg::S_R_B: mem_raddr = na_q;
			ffla_pkg::S_R_W1: begin
				mem_we = b_q < CW'(DEPTH);
				mem_waddr = b_q;
				mem_wdata.units = merge1 ? CW'(ub_q + un_q) : ub_q;
				mem_wdata.next = merge1 ? nn_q : na_q;
			end
			ffla_pkg::S_R_AT_RD: mem_raddr = at_q;
			ffla_pkg::S_R_AT: mem_raddr = b_q;
			ffla_pkg::S_R_BB: begin
				mem_we = at_q < CW'(DEPTH);
				mem_waddr = at_q;
				mem_wdata.units = merge2 ? CW'(ua_q + rd.units) : ua_q;
				mem_wdata.next = merge2 ? rd.next : b_q;
			end
			ffla_pkg::S_G_START: mem_raddr = rover_q;
			ffla_pkg::S_G_FIRST: mem_raddr = rd.next;
			ffla_pkg::S_G_CUR: mem_raddr = rd.next;
			ffla_pkg::S_G_ADV_RD: mem_raddr = rover_q;
			ffla_pkg::S_G_ADV: mem_raddr = rd.next;
			ffla_pkg::S_G_S_RD: mem_raddr = cur_q;
			ffla_pkg::S_G_S: begin
				mem_we = rest < CW'(DEPTH);
				mem_waddr = rest;
				mem_wdata.units = CW'(rd.units - need_q);
				mem_wdata.next = rd.next;
			end
			ffla_pkg::S_PUT_RD: mem_raddr = put_addr_q;
			ffla_pkg::S_PUT_WR: begin
				mem_we = put_addr_q < CW'(DEPTH);
				mem_waddr = put_addr_q;
				mem_wdata.units = put_sel_q ? rd.units : put_val_q;
				mem_wdata.next = put_sel_q ? put_val_q : rd.next;
			end
			default: mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffla_pkg::S_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
			rover_q <= '0;
			pages_q <= '0;
			limit_q <= ffla_pkg::LIMIT_W'(ffla_pkg::LIMIT_RESET);
		end else begin
			state_q <= nxt;
			done_q <= state_q == ffla_pkg::S_FIN;
			if (state_q == ffla_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
			if (page_limit_we) limit_q <= page_limit;
			if (state_q == ffla_pkg::S_R_BB) rover_q <= at_q;
			if (state_q == ffla_pkg::S_G_WIN) rover_q <= prev_q;
			if (state_q == ffla_pkg::S_G_CUR && !g_hit && g_wrap && !g_nopage)
				pages_q <= pages_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		rd_oob_q <= mem_raddr >= CW'(DEPTH);
		unique case (state_q)
			ffla_pkg::S_IDLE: begin
				res_status_q <= too_large && req_type == ffla_pkg::REQ_ALLOC ?
					ffla_pkg::ST_TOO_LARGE : ffla_pkg::ST_IGNORED;
				res_addr_q <= '0;
				res_bytes_q <= '0;
				need_q <= need_in;
				b_q <= h_in;
				at_q <= rover_q;
				rsteps_q <= '0;
				gsteps_q <= '0;
				rel_grant_q <= 1'b0;
			end
			ffla_pkg::S_Q_DO: begin
				res_status_q <= ffla_pkg::ST_OK;
				res_bytes_q <= (|qbytes[CW+ffla_pkg::UNIT_SHIFT-1:OW]) ? {OW{1'b1}} :
					qbytes[OW-1:0];
			end
			ffla_pkg::S_R_WALK: begin
				na_q <= rd.next;
				if (!r_found) begin
					at_q <= rd.next;
					rsteps_q <= rsteps_q + SW'(1);
					if (r_over) res_status_q <= ffla_pkg::ST_OOM;
				end
			end
			ffla_pkg::S_R_B: ub_q <= rd.units;
			ffla_pkg::S_R_N: begin
				un_q <= rd.units;
				nn_q <= rd.next;
			end
			ffla_pkg::S_R_AT: ua_q <= rd.units;
			ffla_pkg::S_R_BB: if (!rel_grant_q) res_status_q <= ffla_pkg::ST_OK;
			ffla_pkg::S_G_START: prev_q <= rover_q;
			ffla_pkg::S_G_FIRST: cur_q <= rd.next;
			ffla_pkg::S_G_CUR: begin
				put_addr_q <= prev_q;
				put_sel_q <= 1'b1;
				put_val_q <= g_exact ? rd.next : rest;
				ret_q <= g_exact ? ffla_pkg::S_G_WIN : ffla_pkg::S_G_S_RD;
				if (!g_hit) begin
					if (g_wrap) begin
						if (g_nopage) res_status_q <= ffla_pkg::ST_OOM;
						put_addr_q <= base;
						put_sel_q <= 1'b0;
						put_val_q <= CW'(PAGE_UNITS);
						ret_q <= ffla_pkg::S_R_WALK_RD;
						b_q <= base;
						at_q <= rover_q;
						rsteps_q <= '0;
						rel_grant_q <= 1'b1;
					end else begin
						prev_q <= cur_q;
						cur_q <= rd.next;
						gsteps_q <= gsteps_q + SW'(1);
						if (g_over) res_status_q <= ffla_pkg::ST_OOM;
					end
				end
			end
			ffla_pkg::S_G_ADV: begin
				prev_q <= rover_q;
				cur_q <= rd.next;
				gsteps_q <= gsteps_q + SW'(1);
				if (g_over) res_status_q <= ffla_pkg::ST_OOM;
			end
			ffla_pkg::S_G_S: begin
				put_addr_q <= cur_q;
				put_sel_q <= 1'b0;
				put_val_q <= need_q;
				ret_q <= ffla_pkg::S_G_WIN;
			end
			ffla_pkg::S_G_WIN: begin
				res_status_q <= ffla_pkg::ST_OK;
				res_addr_q <= OW'(cur_q + CW'(1));
			end
			default: ;
		endcase
	end
endmodule

// ----- src/ffla_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ffla_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/ffla_checker.sv -----
// Port-level checker for the allocator and its bind to the top level.
// Depends on assert_macros.svh and ffla_pkg.
`include "assert_macros.svh"

module ffla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [12:0] result_addr,
	input logic [12:0] block_bytes
);
	`FFLA_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`FFLA_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`FFLA_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	`FFLA_ASSERT_IMP(a_addr_ok, clk, arst_n, done && result_addr != 13'd0, status == ffla_pkg::ST_OK)
	`FFLA_ASSERT_IMP(a_bytes_ok, clk, arst_n, done && block_bytes != 13'd0, status == ffla_pkg::ST_OK)
endmodule

bind first_fit_free_list_allocator_unit ffla_checker u_ffla_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.result_addr (result_addr),
	.block_bytes (block_bytes)
);

// ----- tb/sv/tb_first_fit_free_list_allocator_unit.sv -----
// Testbench of the first-fit free list allocator: directed and random requests,
// each result checked against an internal heap predictor. Depends on ffla_pkg and the unit.
module tb_first_fit_free_list_allocator_unit;
	localparam int DEPTH = 4097;
	localparam int PG_UNITS = 256;
	localparam int N_PAGES = 16;
	localparam int WALK_MAX = (N_PAGES + 2) * DEPTH;
	localparam int MASK17 = 32'h1FFFF;

	typedef struct {
		logic [1:0]  req;
		logic [11:0] size;
		logic [12:0] addr;
	} req_item_t;

	typedef struct {
		logic [1:0]  status;
		logic [12:0] addr;
		logic [12:0] bytes;
	} reply_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] req_type = 0;
	logic [11:0] size_bytes = 0;
	logic [12:0] block_addr = 0;
	logic page_limit_we = 0;
	logic [4:0] page_limit = 0;
	logic done;
	logic [1:0] status;
	logic [12:0] result_addr;
	logic [12:0] block_bytes;

	first_fit_free_list_allocator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .size_bytes(size_bytes), .block_addr(block_addr),
		.page_limit_we(page_limit_we), .page_limit(page_limit),
		.done(done), .status(status), .result_addr(result_addr),
		.block_bytes(block_bytes)
	);

	req_item_t pending_reqs[$];
	reply_t expected_replies[$];
	int unsigned live_blocks[$];
	int errors = 0;
	int accepted = 0;

	int unsigned heap_units[DEPTH];
	int unsigned heap_next[DEPTH];
	int unsigned rover;
	int unsigned pages_used;
	int unsigned limit_pages;

	initial forever #1 clk = ~clk;

	initial begin
		#8000000;
		$display("[first_fit_free_list_allocator_unit] ERROR");
		$finish;
	end

	function automatic int unsigned rd_units(int unsigned i);
		return i < DEPTH ? heap_units[i] : 0;
	endfunction

	function automatic int unsigned rd_next(int unsigned i);
		return i < DEPTH ? heap_next[i] : 0;
	endfunction

	function automatic void wr_units(int unsigned i, int unsigned v);
		if (i < DEPTH) heap_units[i] = v & MASK17;
	endfunction

	function automatic void wr_next(int unsigned i, int unsigned v);
		if (i < DEPTH) heap_next[i] = v & MASK17;
	endfunction

	function automatic bit link_free_block(int unsigned b);
		int unsigned at;
		int unsigned steps;
		at = rover;
		steps = 0;
		while (!(b > at && b < rd_next(at))) begin
			if (at >= rd_next(at) && (b > at || b < rd_next(at))) break;
			at = rd_next(at);
			steps++;
			if (steps > WALK_MAX) return 0;
		end
		if (rd_next(at) != 0 && ((b + rd_units(b)) & MASK17) == rd_next(at)) begin
			wr_units(b, rd_units(b) + rd_units(rd_next(at)));
			wr_next(b, rd_next(rd_next(at)));
		end else begin
			wr_next(b, rd_next(at));
		end
		if (at != 0 && ((at + rd_units(at)) & MASK17) == b) begin
			wr_units(at, rd_units(at) + rd_units(b));
			wr_next(at, rd_next(b));
		end else begin
			wr_next(at, b);
		end
		rover = at;
		return 1;
	endfunction

	function automatic int unsigned first_fit(int unsigned need);
		int unsigned prev;
		int unsigned cur;
		int unsigned steps;
		int unsigned base;
		int unsigned rest;
		prev = rover;
		cur = rd_next(prev);
		steps = 0;
		forever begin
			if (cur != 0 && rd_units(cur) >= need) begin
				if (rd_units(cur) == need) begin
					wr_next(prev, rd_next(cur));
				end else begin
					rest = (cur + need) & MASK17;
					wr_next(prev, rest);
					wr_units(rest, rd_units(cur) - need);
					wr_next(rest, rd_next(cur));
					wr_units(cur, need);
				end
				rover = prev;
				return cur;
			end
			if (cur == rover) begin
				if (pages_used >= limit_pages || pages_used >= N_PAGES) return 0;
				base = 1 + pages_used * PG_UNITS;
				pages_used++;
				wr_units(base, PG_UNITS);
				if (!link_free_block(base)) return 0;
				cur = rover;
			end
			prev = cur;
			cur = rd_next(cur);
			steps++;
			if (steps > WALK_MAX) return 0;
		end
	endfunction

	function automatic void drop_live(int unsigned a);
		foreach (live_blocks[i]) begin
			if (live_blocks[i] == a) begin
				live_blocks.delete(i);
				return;
			end
		end
	endfunction

	function automatic reply_t predict_reply(req_item_t it);
		reply_t r;
		int unsigned h;
		int unsigned b;
		r.status = ffla_pkg::ST_IGNORED;
		r.addr = 0;
		r.bytes = 0;
		if (it.req == ffla_pkg::REQ_ALLOC) begin
			if (it.size >= PG_UNITS * ffla_pkg::UNIT_BYTES - ffla_pkg::UNIT_BYTES) begin
				r.status = ffla_pkg::ST_TOO_LARGE;
			end else begin
				h = first_fit((it.size + 2 * ffla_pkg::UNIT_BYTES - 1) /
					ffla_pkg::UNIT_BYTES);
				if (h == 0) begin
					r.status = ffla_pkg::ST_OOM;
				end else begin
					r.status = ffla_pkg::ST_OK;
					r.addr = 13'(h + 1);
					live_blocks.push_back(32'(r.addr));
				end
			end
		end else if (it.req == ffla_pkg::REQ_FREE || it.req == ffla_pkg::REQ_QUERY) begin
			h = 32'(it.addr) - 1;
			if (it.addr >= 2 && h < DEPTH) begin
				if (it.req == ffla_pkg::REQ_FREE) begin
					r.status = link_free_block(h) ? ffla_pkg::ST_OK : ffla_pkg::ST_OOM;
					drop_live(32'(it.addr));
				end else begin
					b = rd_units(h) * ffla_pkg::UNIT_BYTES;
					r.bytes = 13'(b > 8191 ? 8191 : b);
					r.status = ffla_pkg::ST_OK;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		req_item_t nx;
		bit go;
		if (start && !busy) begin
			nx.req = req_type;
			nx.size = size_bytes;
			nx.addr = block_addr;
			expected_replies.push_back(predict_reply(nx));
			accepted++;
			pending_reqs.pop_front();
		end
		go = (accepted >= 700 && accepted < 1000) || $urandom_range(99) >= 27;
		if (pending_reqs.size() != 0 && go && arst_n) begin
			start <= 1;
			req_type <= pending_reqs[0].req;
			size_bytes <= pending_reqs[0].size;
			block_addr <= pending_reqs[0].addr;
		end else begin
			start <= 0;
		end
	end

	always @(posedge clk) begin
		reply_t e;
		if (done) begin
			if (expected_replies.size() == 0) begin
				$display("%0t unexpected result status=%0d addr=%0d bytes=%0d",
					$time, status, result_addr, block_bytes);
				errors++;
			end else begin
				e = expected_replies.pop_front();
				if (status !== e.status)
					$display("%0t status expected %0d actual %0d", $time, e.status, status);
				if (result_addr !== e.addr)
					$display("%0t result_addr expected %0d actual %0d",
						$time, e.addr, result_addr);
				if (block_bytes !== e.bytes)
					$display("%0t block_bytes expected %0d actual %0d",
						$time, e.bytes, block_bytes);
				if (status !== e.status || result_addr !== e.addr || block_bytes !== e.bytes)
					errors++;
			end
		end
	end

	task automatic send(int unsigned rq, int unsigned sz, int unsigned ad);
		req_item_t it;
		it.req = 2'(rq);
		it.size = 12'(sz);
		it.addr = 13'(ad);
		pending_reqs.push_back(it);
		while (pending_reqs.size() != 0) @(posedge clk);
	endtask

	task automatic drain_and_set_limit(int unsigned v);
		while (expected_replies.size() != 0 || start || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		page_limit_we <= 1;
		page_limit <= 5'(v);
		@(posedge clk);
		page_limit_we <= 0;
		limit_pages = v & 31;
	endtask

	function automatic int unsigned pick_live();
		return live_blocks[$urandom_range(live_blocks.size() - 1)];
	endfunction

	task automatic random_phase(int n);
		int k;
		repeat (n) begin
			k = $urandom_range(99);
			if (k < 45 || (k < 92 && live_blocks.size() == 0)) begin
				k = $urandom_range(99);
				if (k < 85) send(ffla_pkg::REQ_ALLOC, $urandom_range(255), 0);
				else if (k < 95) send(ffla_pkg::REQ_ALLOC, $urandom_range(4079), 0);
				else send(ffla_pkg::REQ_ALLOC, $urandom_range(4095, 4080), 0);
			end else if (k < 80) begin
				send(ffla_pkg::REQ_FREE, $urandom, pick_live());
			end else if (k < 92) begin
				send(ffla_pkg::REQ_QUERY, $urandom, pick_live());
			end else if (k < 95) begin
				send($urandom_range(1) ? ffla_pkg::REQ_FREE : ffla_pkg::REQ_QUERY, $urandom,
					$urandom_range(1));
			end else if (k < 98) begin
				send(ffla_pkg::REQ_NONE, $urandom, $urandom);
			end else begin
				send(ffla_pkg::REQ_QUERY, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		foreach (heap_units[i]) begin
			heap_units[i] = 0;
			heap_next[i] = 0;
		end
		heap_units[0] = 1;
		rover = 0;
		pages_used = 0;
		limit_pages = ffla_pkg::LIMIT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		drain_and_set_limit(1);
		send(ffla_pkg::REQ_ALLOC, 0, 0);
		send(ffla_pkg::REQ_ALLOC, 4079, 0);
		send(ffla_pkg::REQ_ALLOC, 4080, 0);
		send(ffla_pkg::REQ_ALLOC, 4095, 0);
		send(ffla_pkg::REQ_ALLOC, 2000, 0);
		send(ffla_pkg::REQ_ALLOC, 2000, 0);
		send(ffla_pkg::REQ_QUERY, 0, live_blocks[0]);
		send(ffla_pkg::REQ_FREE, 4095, 0);
		send(ffla_pkg::REQ_QUERY, 4095, 0);
		send(ffla_pkg::REQ_FREE, 0, 1);
		send(ffla_pkg::REQ_QUERY, 0, 1);
		send(ffla_pkg::REQ_QUERY, 0, 8191);
		send(ffla_pkg::REQ_FREE, 0, 8191);
		send(ffla_pkg::REQ_QUERY, 0, 4098);
		send(ffla_pkg::REQ_QUERY, 0, 4097);
		send(ffla_pkg::REQ_NONE, 4095, 8191);
		send(ffla_pkg::REQ_NONE, 0, 0);
		while (live_blocks.size() != 0) send(ffla_pkg::REQ_FREE, 0, live_blocks[0]);
		send(ffla_pkg::REQ_ALLOC, 4078, 0);
		drain_and_set_limit(0);
		random_phase(200);
		drain_and_set_limit(31);
		random_phase(700);
		drain_and_set_limit(16);
		random_phase(600);
		drain_and_set_limit($urandom_range(15, 2));
		random_phase(300);
		repeat (5) send(ffla_pkg::REQ_FREE, $urandom, $urandom_range(4096, 2));
		while (expected_replies.size() != 0 || start) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("[first_fit_free_list_allocator_unit] OK");
		end else begin
			$display("[first_fit_free_list_allocator_unit] ERROR");
		end
		$finish;
	end
endmodule

// ----- first_fit_free_list_allocator_unit.f -----
+incdir+src
src/ffla_pkg.sv
src/ffla_ram.sv
src/first_fit_free_list_allocator_unit.sv
src/ffla_checker.sv
tb/sv/tb_first_fit_free_list_allocator_unit.sv
